@@ sv/mmn_pkg.sv @@
// Shared types, constants and helper functions of the mecanum mixer.
`default_nettype none
package mmn_pkg;

  localparam int WHEEL_W      = 10;
  localparam int MAG_W        = 9;
  localparam int DIVD_W       = 16;
  localparam int QBITS        = 7;
  localparam int NSTG         = QBITS + 1;
  localparam int NWHEEL       = 4;
  localparam int WHEEL_LIMIT  = 127;
  localparam int MMN_MID_DEPTH = 2;
  localparam int MMN_OUT_DEPTH = 2;

  localparam int WH_FL = 0;
  localparam int WH_FR = 1;
  localparam int WH_BL = 2;
  localparam int WH_BR = 3;

  typedef logic signed [WHEEL_W-1:0] wheel_t;
  typedef logic [MAG_W-1:0]          mag_t;

  typedef struct packed {
    wheel_t [NWHEEL-1:0] w;
    mag_t                m;
    logic                scale;
  } mix_t;

  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [QBITS-1:0]  q;
    wheel_t            w;
  } lane_t;

  typedef struct packed {
    logic               valid;
    logic               scale;
    mag_t               m;
    lane_t [NWHEEL-1:0] lane;
  } bstage_t;

  typedef struct packed {
    logic [7:0] fl;
    logic [7:0] fr;
    logic [7:0] bl;
    logic [7:0] br;
  } pwm_t;

  function automatic mag_t wheel_mag(input wheel_t w);
    logic [WHEEL_W-1:0] t;
    t = w[WHEEL_W-1] ? -w : w;
    return t[MAG_W-1:0];
  endfunction

  function automatic logic [7:0] to_pwm(input wheel_t w);
    logic [WHEEL_W-1:0] s;
    s = w + WHEEL_W'(WHEEL_LIMIT) + ((w > 0) ? WHEEL_W'(1) : WHEEL_W'(0));
    return s[7:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/mecanum_mix_normalized_top.sv @@
// Top level of the normalized mecanum wheel mixer.
// Takes one joystick frame (strafe, forward, spin) per cycle and returns four wheel PWM
// bytes, 127 meaning stop, with all wheels scaled by 127/peak when the peak exceeds 127.
// Sustained rate is one frame per cycle; a frame's result reaches the result side through
// the input register, classify queue, a load stage and seven divider stages that each
// resolve one quotient bit, and the result queue. Results keep frame order, and both
// sides may stall independently.
`default_nettype none
module mecanum_mix_normalized_top #(
  parameter int MID_DEPTH = mmn_pkg::MMN_MID_DEPTH,
  parameter int OUT_DEPTH = mmn_pkg::MMN_OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic signed [7:0] strafe,
  input  logic signed [7:0] forward,
  input  logic signed [7:0] spin,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        front_left_pwm,
  output logic [7:0]        front_right_pwm,
  output logic [7:0]        back_left_pwm,
  output logic [7:0]        back_right_pwm
);
  import mmn_pkg::*;

  mix_t mid_wdata;
  mix_t mid_rdata;
  logic mid_push;
  logic mid_full;
  logic mid_pop;
  logic mid_empty;
  pwm_t out_wdata;
  pwm_t out_rdata;
  logic out_push;
  logic out_full;

  mmn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .strafe   (strafe),
    .forward  (forward),
    .spin     (spin),
    .full     (full),
    .mid_push (mid_push),
    .mid_data (mid_wdata),
    .mid_full (mid_full)
  );

  mmn_fifo #(
    .WIDTH ($bits(mix_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  mmn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_pop   (mid_pop),
    .mid_data  (mid_rdata),
    .mid_empty (mid_empty),
    .out_push  (out_push),
    .out_data  (out_wdata),
    .out_full  (out_full)
  );

  mmn_fifo #(
    .WIDTH ($bits(pwm_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign front_left_pwm  = out_rdata.fl;
  assign front_right_pwm = out_rdata.fr;
  assign back_left_pwm   = out_rdata.bl;
  assign back_right_pwm  = out_rdata.br;

endmodule
`default_nettype wire

@@ sv/mmn_fifo.sv @@
// Small register queue with registered storage and occupancy count.
`default_nettype none
module mmn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/mmn_front.sv @@
// Front end: forms wheel sums, finds peak magnitude, flags frames that need scaling.
`default_nettype none
module mmn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic signed [7:0]  strafe,
  input  logic signed [7:0]  forward,
  input  logic signed [7:0]  spin,
  output logic               full,
  output logic               mid_push,
  output mmn_pkg::mix_t      mid_data,
  input  logic               mid_full
);
  import mmn_pkg::*;

  logic                valid;
  wheel_t [NWHEEL-1:0] whl;
  wheel_t              x;
  wheel_t              y;
  wheel_t              z;
  logic                load;
  mag_t [NWHEEL-1:0]   mg;
  mag_t                m01;
  mag_t                m23;
  mag_t                mx;

  assign x        = wheel_t'(strafe);
  assign y        = wheel_t'(forward);
  assign z        = wheel_t'(spin);
  assign full     = valid && mid_full;
  assign load     = push && !full;
  assign mid_push = valid && !mid_full;

  always_comb begin
    for (int i = 0; i < NWHEEL; i++) begin
      mg[i] = wheel_mag(whl[i]);
    end
    m01 = (mg[1] > mg[0]) ? mg[1] : mg[0];
    m23 = (mg[3] > mg[2]) ? mg[3] : mg[2];
    mx  = (m23 > m01) ? m23 : m01;
    mid_data.w     = whl;
    mid_data.m     = mx;
    mid_data.scale = (mx > MAG_W'(WHEEL_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      whl[WH_FL] <= y + x - z;
      whl[WH_FR] <= y - x + z;
      whl[WH_BL] <= y - x - z;
      whl[WH_BR] <= y + x + z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (mid_push) begin
      valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ sv/mmn_back.sv @@
// Back end: pipelined restoring divider, a load stage then one quotient bit per stage, and PWM offset.
`default_nettype none
module mmn_back (
  input  logic           clk,
  input  logic           rst,
  output logic           mid_pop,
  input  mmn_pkg::mix_t  mid_data,
  input  logic           mid_empty,
  output logic           out_push,
  output mmn_pkg::pwm_t  out_data,
  input  logic           out_full
);
  import mmn_pkg::*;

  bstage_t              stg [NSTG];
  bstage_t              stg_next [NSTG];
  logic                 adv;
  mag_t                 a;
  logic [DIVD_W-1:0]    trial;
  wheel_t [NWHEEL-1:0]  wf;
  wheel_t               qs;

  assign adv      = !(stg[NSTG-1].valid && out_full);
  assign mid_pop  = adv && !mid_empty;
  assign out_push = stg[NSTG-1].valid && !out_full;

  always_comb begin
    stg_next[0].valid = !mid_empty;
    stg_next[0].scale = mid_data.scale;
    stg_next[0].m     = mid_data.m;
    for (int l = 0; l < NWHEEL; l++) begin
      a = wheel_mag(mid_data.w[l]);
      stg_next[0].lane[l].rem = (DIVD_W'(a) << QBITS) - DIVD_W'(a);
      stg_next[0].lane[l].q   = '0;
      stg_next[0].lane[l].w   = mid_data.w[l];
    end
    for (int k = 1; k < NSTG; k++) begin
      stg_next[k] = stg[k-1];
      for (int l = 0; l < NWHEEL; l++) begin
        trial = DIVD_W'(stg[k-1].m) << (QBITS - k);
        if (stg[k-1].lane[l].rem >= trial) begin
          stg_next[k].lane[l].rem         = stg[k-1].lane[l].rem - trial;
          stg_next[k].lane[l].q[QBITS-k]  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NWHEEL; l++) begin
      qs = wheel_t'({{(WHEEL_W-QBITS){1'b0}}, stg[NSTG-1].lane[l].q});
      if (!stg[NSTG-1].scale) begin
        wf[l] = stg[NSTG-1].lane[l].w;
      end else if (stg[NSTG-1].lane[l].w < 0) begin
        wf[l] = -qs;
      end else begin
        wf[l] = qs;
      end
    end
    out_data.fl = to_pwm(wf[WH_FL]);
    out_data.fr = to_pwm(wf[WH_FR]);
    out_data.bl = to_pwm(wf[WH_BL]);
    out_data.br = to_pwm(wf[WH_BR]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) begin
        stg[k].valid <= 1'b0;
      end
    end else if (adv) begin
      stg <= stg_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/mmn_checker.sv @@
// Port-level checks of the mixer, bound to the top level.
`default_nettype none
module mmn_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [7:0]        front_left_pwm,
  input logic [7:0]        front_right_pwm,
  input logic [7:0]        back_left_pwm,
  input logic [7:0]        back_right_pwm
);

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_front_byte: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (front_left_pwm != 8'd128) && (front_right_pwm != 8'd128))
    else $error("front wheel byte holds unreachable code");

  a_back_byte: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (back_left_pwm != 8'd128) && (back_right_pwm != 8'd128))
    else $error("back wheel byte holds unreachable code");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(front_left_pwm) && $stable(back_right_pwm))
    else $error("waiting beat changed");

endmodule

bind mecanum_mix_normalized_top mmn_checker u_mmn_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the normalized mecanum wheel mixer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mmn_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_FRAMES = 530;
  localparam int CALM_TAIL = 60;
  localparam int DRAIN_CYCLES = 30;

  typedef logic signed [7:0] axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  axis_t strafe = '0;
  axis_t forward = '0;
  axis_t spin = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] front_left_pwm;
  logic [7:0] front_right_pwm;
  logic [7:0] back_left_pwm;
  logic [7:0] back_right_pwm;

  frame_t frame_q[$];
  pwm_t wheel_bytes_q[$];
  int total_frames = 0;
  int accepted = 0;
  int checked = 0;
  int scaled_frames = 0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int hold_gap = 0;

  mecanum_mix_normalized_top DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .strafe(strafe),
    .forward(forward),
    .spin(spin),
    .empty(empty),
    .pop(pop),
    .front_left_pwm(front_left_pwm),
    .front_right_pwm(front_right_pwm),
    .back_left_pwm(back_left_pwm),
    .back_right_pwm(back_right_pwm)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic pwm_t mix_wheel_bytes(input int x, input int y, input int z,
                                           output bit scaled);
    int w[NWHEEL];
    int peak;
    int mag_now;
    int q;
    logic [7:0] b[NWHEEL];
    pwm_t r;
    w[WH_FL] = y + x - z;
    w[WH_FR] = y - x + z;
    w[WH_BL] = y - x - z;
    w[WH_BR] = y + x + z;
    peak = 0;
    foreach (w[i]) begin
      mag_now = (w[i] < 0) ? -w[i] : w[i];
      if (mag_now > peak) peak = mag_now;
    end
    scaled = (peak > WHEEL_LIMIT);
    foreach (w[i]) begin
      if (scaled) begin
        mag_now = (w[i] < 0) ? -w[i] : w[i];
        q = (WHEEL_LIMIT * mag_now) / peak;
        w[i] = (w[i] < 0) ? -q : q;
      end
      b[i] = 8'(w[i] + WHEEL_LIMIT + ((w[i] > 0) ? 1 : 0));
    end
    r.fl = b[WH_FL];
    r.fr = b[WH_FR];
    r.bl = b[WH_BL];
    r.br = b[WH_BR];
    return r;
  endfunction

  function automatic bit start_gap(input int progress);
    if (progress >= total_frames - CALM_TAIL) return 1'b0;
    if ((progress / 64) % 3 == 1) return 1'b0;
    return ($urandom_range(0, 6) == 0);
  endfunction

  function automatic axis_t rand_axis(input int kind);
    int v;
    case (kind)
      0: begin
        return axis_t'($urandom_range(0, 255));
      end
      1: begin
        return axis_t'(int'($urandom_range(0, 80)) - 40);
      end
      2: begin
        v = $urandom_range(96, 128);
        if ($urandom_range(0, 1)) return axis_t'(-v);
        return axis_t'((v > 127) ? 127 : v);
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  task automatic add_frame(input int x, input int y, input int z);
    frame_t f;
    f.x = axis_t'(x);
    f.y = axis_t'(y);
    f.z = axis_t'(z);
    frame_q.push_back(f);
    total_frames++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_t f;
    bit scaled;
    pwm_t bytes;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        bytes = mix_wheel_bytes(strafe, forward, spin, scaled);
        wheel_bytes_q.push_back(bytes);
        if (scaled) scaled_frames++;
        accepted++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (frame_q.size() > 0) begin
          if (start_gap(accepted)) begin
            send_gap = $urandom_range(1, 11) - 1;
            push <= 1'b0;
          end else begin
            f = frame_q.pop_front();
            strafe <= f.x;
            forward <= f.y;
            spin <= f.z;
            push <= 1'b1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pwm_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (wheel_bytes_q.size() == 0) begin
          $error("result beat with no frame outstanding");
          errors++;
        end else begin
          want = wheel_bytes_q.pop_front();
          check_field("front_left_pwm", want.fl, front_left_pwm);
          check_field("front_right_pwm", want.fr, front_right_pwm);
          check_field("back_left_pwm", want.bl, back_left_pwm);
          check_field("back_right_pwm", want.br, back_right_pwm);
          checked++;
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        pop <= 1'b0;
      end else if (start_gap(checked)) begin
        hold_gap = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("mecanum_mix_normalized_top: mismatch");
      $finish;
    end
  end

  initial begin
    int kind;
    add_frame(0, 0, 0);
    add_frame(127, 0, 0);
    add_frame(0, 127, 0);
    add_frame(0, 0, 127);
    add_frame(-128, 0, 0);
    add_frame(0, -128, 0);
    add_frame(0, 0, -128);
    add_frame(-127, 0, 0);
    add_frame(64, 64, 0);
    add_frame(64, 63, 0);
    add_frame(127, 127, 127);
    add_frame(-128, -128, -128);
    add_frame(127, -128, 127);
    add_frame(-128, 127, -128);
    add_frame(127, 127, -128);
    add_frame(-128, -128, 127);
    add_frame(100, 100, 100);
    add_frame(-100, 50, -25);
    add_frame(1, -1, 1);
    add_frame(-1, 1, -1);
    add_frame(50, 50, -50);
    add_frame(85, -85, 85);
    repeat (RANDOM_FRAMES) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        add_frame(rand_axis(0), rand_axis(0), rand_axis(0));
      end else if (kind <= 5) begin
        add_frame(rand_axis(1), rand_axis(1), rand_axis(1));
      end else if (kind <= 7) begin
        add_frame(rand_axis(2), rand_axis(2), rand_axis($urandom_range(0, 2)));
      end else begin
        case ($urandom_range(0, 2))
          0: add_frame(0, rand_axis(0), rand_axis(0));
          1: add_frame(rand_axis(0), 0, rand_axis(0));
          default: add_frame(rand_axis(0), rand_axis(0), 0);
        endcase
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (accepted == total_frames);
    wait (wheel_bytes_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d joystick frames sent, %0d of them needed peak scaling", total_frames,
             scaled_frames);
    $display("%0d wheel byte sets checked, %0d field errors", checked, errors);
    if (errors == 0) begin
      $display("mecanum_mix_normalized_top: match");
    end else begin
      $display("mecanum_mix_normalized_top: mismatch");
    end
    $finish;
  end

endmodule
